// ===== rtl/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, operation codes, pipeline tag and fixed-point helpers for the
// quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int WORD_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int HALF       = 1 << (FRAC_W - 1);
  localparam int PROD_W     = 20;
  localparam int SQR_W      = 2 * WORD_W - 1;
  localparam int MID_W      = 22;
  localparam int RES_W      = 28;
  localparam int TOL_W      = 12;
  localparam int SQ_W       = 33;
  localparam int LS_W       = 21;
  localparam int ROOT_W     = 17;
  localparam int SQRT_STEPS = 17;
  localparam int SQRT_W     = 35;
  localparam int DIVS_W     = 21;
  localparam int QUO_W      = 16;
  localparam int NUM_W      = 29;
  localparam int CMP_W      = DIVS_W + QUO_W;

  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_SCALE = 3'd3,
    MODE_CONJ  = 3'd4,
    MODE_INV   = 3'd5,
    MODE_NORM  = 3'd6,
    MODE_ROT   = 3'd7
  } mode_t;

  // Element 0 is x, 1 is y, 2 is z and 3 is w.
  typedef logic [3:0][WORD_W-1:0] quat_t;
  typedef logic [3:0][RES_W-1:0]  res_t;

  typedef struct packed {
    mode_t             mode;
    quat_t             a;
    res_t              res;
    logic              zn;
    logic [LS_W-1:0]   ls;
  } tag_t;

  // Product of two words rounded to FRAC_W fraction bits, half upwards.
  function automatic logic signed [PROD_W-1:0] fmul_w(input logic signed [WORD_W-1:0] x,
                                                      input logic signed [WORD_W-1:0] y);
    logic signed [2*WORD_W-1:0] p;
    logic signed [2*WORD_W-1:0] h;
    p = x * y;
    h = (2 * WORD_W)'(HALF);
    return PROD_W'((p + h) >>> FRAC_W);
  endfunction

  // Product of a wide intermediate and a word, rounded in the same way.
  function automatic logic signed [RES_W-1:0] fmul_m(input logic signed [MID_W-1:0] x,
                                                     input logic signed [WORD_W-1:0] y);
    logic signed [MID_W+WORD_W-1:0] p;
    logic signed [MID_W+WORD_W-1:0] h;
    p = x * y;
    h = (MID_W + WORD_W)'(HALF);
    return RES_W'((p + h) >>> FRAC_W);
  endfunction

  // Exact square of a word.
  function automatic logic [SQR_W-1:0] sq_w(input logic signed [WORD_W-1:0] x);
    logic signed [2*WORD_W-1:0] p;
    p = x * x;
    return SQR_W'(p);
  endfunction

endpackage

// ===== rtl/qau_in_if.sv =====
// ----------------------------------------------------------------------------
// qau_in_if
// Request channel of the quaternion arithmetic unit: mode and two operands.
// ----------------------------------------------------------------------------
interface qau_in_if;
  import qau_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [WORD_W-1:0]  a_x;
  logic [WORD_W-1:0]  a_y;
  logic [WORD_W-1:0]  a_z;
  logic [WORD_W-1:0]  a_w;
  logic [WORD_W-1:0]  b_x;
  logic [WORD_W-1:0]  b_y;
  logic [WORD_W-1:0]  b_z;
  logic [WORD_W-1:0]  b_w;

  modport source (output valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface

// ===== rtl/qau_out_if.sv =====
// ----------------------------------------------------------------------------
// qau_out_if
// Result channel of the quaternion arithmetic unit: quaternion and flags.
// ----------------------------------------------------------------------------
interface qau_out_if;
  import qau_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  r_x;
  logic [WORD_W-1:0]  r_y;
  logic [WORD_W-1:0]  r_z;
  logic [WORD_W-1:0]  r_w;
  logic               zero_norm;
  logic               saturated;

  modport source (output valid, r_x, r_y, r_z, r_w, zero_norm, saturated, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, zero_norm, saturated, output ready);
endinterface

// ===== rtl/qau_arith.sv =====
// ----------------------------------------------------------------------------
// qau_arith
// Four-stage front end: operand products, sums for the direct operations and
// the rotation terms, rotation products and zero checks, and rotation sums.
// ----------------------------------------------------------------------------
module qau_arith (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  qau_pkg::mode_t              in_mode,
  input  qau_pkg::quat_t              in_a,
  input  qau_pkg::quat_t              in_b,
  input  logic [qau_pkg::TOL_W-1:0]   tol,
  output logic                        out_v,
  output qau_pkg::tag_t               out_tag,
  output logic [qau_pkg::SQ_W-1:0]    out_sq
);
  import qau_pkg::*;

  logic                     v1_r;
  mode_t                    mode1_r;
  quat_t                    a1_r;
  quat_t                    b1_r;
  logic signed [PROD_W-1:0] pm1_r [4][4];
  logic [SQR_W-1:0]         sq1_r [4];

  logic                     v2_r;
  mode_t                    mode2_r;
  quat_t                    a2_r;
  quat_t                    b2_r;
  logic signed [RES_W-1:0]  res2_r [4];
  logic signed [MID_W-1:0]  d2_r;
  logic signed [MID_W-1:0]  k2_r;
  logic signed [MID_W-1:0]  c2_r [3];
  logic [SQ_W-1:0]          s2_r;

  logic                     v3_r;
  mode_t                    mode3_r;
  quat_t                    a3_r;
  logic signed [RES_W-1:0]  res3_r [4];
  logic                     zn3_r;
  logic [LS_W-1:0]          ls3_r;
  logic [SQ_W-1:0]          s3_r;
  logic signed [RES_W-1:0]  pd3_r [3];
  logic signed [RES_W-1:0]  pk3_r [3];
  logic signed [RES_W-1:0]  pc3_r [3];

  logic                     v4_r;
  tag_t                     tag4_r;
  logic [SQ_W-1:0]          s4_r;

  logic signed [RES_W-1:0]  pw [4][4];
  logic signed [RES_W-1:0]  aw [4];
  logic signed [RES_W-1:0]  bw [4];
  logic signed [RES_W-1:0]  fw [4];
  logic signed [RES_W-1:0]  res2_nxt [4];
  logic signed [RES_W-1:0]  vv;
  logic signed [RES_W-1:0]  d2_nxt;
  logic signed [RES_W-1:0]  k2_nxt;
  logic signed [RES_W-1:0]  c2_nxt [3];
  logic [SQ_W-1:0]          s2_nxt;
  logic [LS_W-1:0]          ls3_nxt;
  logic                     zn3_nxt;
  tag_t                     tag4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_mode;
      a1_r    <= in_a;
      b1_r    <= in_b;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pm1_r[i][j] <= fmul_w($signed(in_a[i]), $signed(in_b[j]));
        end
        sq1_r[i] <= sq_w($signed(in_a[i]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pw[i][j] = RES_W'(pm1_r[i][j]);
      end
      aw[i] = RES_W'($signed(a1_r[i]));
      bw[i] = RES_W'($signed(b1_r[i]));
      fw[i] = $signed(RES_W'((SQ_W'(sq1_r[i]) + SQ_W'(HALF)) >> FRAC_W));
    end
    s2_nxt    = SQ_W'(sq1_r[0]) + SQ_W'(sq1_r[1]) + SQ_W'(sq1_r[2]) + SQ_W'(sq1_r[3]);
    d2_nxt    = pw[0][0] + pw[1][1] + pw[2][2];
    vv        = fw[0] + fw[1] + fw[2];
    k2_nxt    = fw[3] - vv;
    c2_nxt[0] = pw[1][2] - pw[2][1];
    c2_nxt[1] = pw[2][0] - pw[0][2];
    c2_nxt[2] = pw[0][1] - pw[1][0];
    for (int i = 0; i < 4; i++) begin
      res2_nxt[i] = '0;
    end
    case (mode1_r)
      MODE_ADD: begin
        for (int i = 0; i < 4; i++) begin
          res2_nxt[i] = aw[i] + bw[i];
        end
      end
      MODE_SUB: begin
        for (int i = 0; i < 4; i++) begin
          res2_nxt[i] = aw[i] - bw[i];
        end
      end
      MODE_MUL: begin
        res2_nxt[0] = pw[3][0] + pw[0][3] + pw[1][2] - pw[2][1];
        res2_nxt[1] = pw[3][1] - pw[0][2] + pw[1][3] + pw[2][0];
        res2_nxt[2] = pw[3][2] + pw[0][1] - pw[1][0] + pw[2][3];
        res2_nxt[3] = pw[3][3] - pw[0][0] - pw[1][1] - pw[2][2];
      end
      MODE_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          res2_nxt[i] = pw[i][3];
        end
      end
      MODE_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          res2_nxt[i] = -aw[i];
        end
        res2_nxt[3] = aw[3];
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          res2_nxt[i] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r <= mode1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      s2_r    <= s2_nxt;
      d2_r    <= MID_W'(d2_nxt);
      k2_r    <= MID_W'(k2_nxt);
      for (int i = 0; i < 3; i++) begin
        c2_r[i] <= MID_W'(c2_nxt[i]);
      end
      for (int i = 0; i < 4; i++) begin
        res2_r[i] <= res2_nxt[i];
      end
    end
  end

  always_comb begin
    ls3_nxt = LS_W'(s2_r >> FRAC_W) + LS_W'(s2_r[FRAC_W-1]);
    case (mode2_r)
      MODE_INV:  zn3_nxt = (ls3_nxt <= LS_W'(tol));
      MODE_NORM: zn3_nxt = (s2_r == '0);
      default:   zn3_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode3_r <= mode2_r;
      a3_r    <= a2_r;
      zn3_r   <= zn3_nxt;
      ls3_r   <= ls3_nxt;
      s3_r    <= s2_r;
      for (int i = 0; i < 4; i++) begin
        res3_r[i] <= res2_r[i];
      end
      for (int i = 0; i < 3; i++) begin
        pd3_r[i] <= fmul_m(d2_r, $signed(a2_r[i]));
        pk3_r[i] <= fmul_m(k2_r, $signed(b2_r[i]));
        pc3_r[i] <= fmul_m(c2_r[i], $signed(a2_r[3]));
      end
    end
  end

  always_comb begin
    tag4_nxt.mode = mode3_r;
    tag4_nxt.a    = a3_r;
    tag4_nxt.zn   = zn3_r;
    tag4_nxt.ls   = ls3_r;
    for (int i = 0; i < 4; i++) begin
      tag4_nxt.res[i] = res3_r[i];
    end
    if (mode3_r == MODE_ROT) begin
      for (int i = 0; i < 3; i++) begin
        tag4_nxt.res[i] = (pd3_r[i] <<< 1) + pk3_r[i] + (pc3_r[i] <<< 1);
      end
      tag4_nxt.res[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag4_r <= tag4_nxt;
      s4_r   <= s3_r;
    end
  end

  assign out_v   = v4_r;
  assign out_tag = tag4_r;
  assign out_sq  = s4_r;

endmodule

// ===== rtl/qau_sqrt.sv =====
// ----------------------------------------------------------------------------
// qau_sqrt
// Pipelined square root of the squared norm, one result bit per stage, with a
// final stage that rounds the root to nearest.
// ----------------------------------------------------------------------------
module qau_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  qau_pkg::tag_t               in_tag,
  input  logic [qau_pkg::SQ_W-1:0]    in_x,
  output logic                        out_v,
  output qau_pkg::tag_t               out_tag,
  output logic [qau_pkg::ROOT_W-1:0]  out_root
);
  import qau_pkg::*;

  logic              v_r    [SQRT_STEPS];
  tag_t              tag_r  [SQRT_STEPS];
  logic [SQRT_W-1:0] x_r    [SQRT_STEPS];
  logic [SQRT_W-1:0] r_r    [SQRT_STEPS];
  logic [SQRT_W-1:0] x_nxt  [SQRT_STEPS];
  logic [SQRT_W-1:0] r_nxt  [SQRT_STEPS];
  logic              fin_v_r;
  tag_t              fin_tag_r;
  logic [ROOT_W-1:0] root_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQRT_W-1:0] STEP_BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQRT_W-1:0] x_src;
    logic [SQRT_W-1:0] r_src;
    logic [SQRT_W-1:0] trial;
    logic              ge;
    if (k == 0) begin : g_first
      assign x_src = SQRT_W'(in_x);
      assign r_src = '0;
    end else begin : g_next
      assign x_src = x_r[k-1];
      assign r_src = r_r[k-1];
    end
    assign trial    = r_src + STEP_BIT;
    assign ge       = (x_src >= trial);
    assign x_nxt[k] = ge ? (x_src - trial) : x_src;
    assign r_nxt[k] = ge ? ((r_src >> 1) + STEP_BIT) : (r_src >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        v_r[k] <= 1'b0;
      end
      fin_v_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        v_r[k] <= v_r[k-1];
      end
      fin_v_r <= v_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        x_r[k] <= x_nxt[k];
        r_r[k] <= r_nxt[k];
      end
      fin_tag_r <= tag_r[SQRT_STEPS-1];
      root_r    <= ROOT_W'(r_r[SQRT_STEPS-1]
                   + SQRT_W'(x_r[SQRT_STEPS-1] > r_r[SQRT_STEPS-1]));
    end
  end

  assign out_v    = fin_v_r;
  assign out_tag  = fin_tag_r;
  assign out_root = root_r;

endmodule

// ===== rtl/qau_div.sv =====
// ----------------------------------------------------------------------------
// qau_div
// Four-lane pipelined divider for invert and normalize: a set-up stage forms
// the rounded numerators and the overflow test, then one quotient bit is
// resolved per stage.
// ----------------------------------------------------------------------------
module qau_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_v,
  input  qau_pkg::tag_t                        in_tag,
  input  logic [qau_pkg::ROOT_W-1:0]           in_root,
  output logic                                 out_v,
  output qau_pkg::tag_t                        out_tag,
  output logic [3:0][qau_pkg::QUO_W-1:0]       out_q,
  output logic [3:0]                           out_neg,
  output logic [3:0]                           out_ovf
);
  import qau_pkg::*;

  typedef struct packed {
    tag_t                   tag;
    logic [DIVS_W-1:0]      dv;
    logic [3:0][NUM_W-1:0]  rem;
    logic [3:0][QUO_W-1:0]  q;
    logic [3:0]             neg;
    logic [3:0]             ovf;
  } dstage_t;

  logic                     pre_v_r;
  dstage_t                  pre_r;
  dstage_t                  pre_nxt;
  logic                     v_r    [QUO_W];
  dstage_t                  st_r   [QUO_W];
  dstage_t                  st_nxt [QUO_W];
  logic signed [WORD_W:0]   ae;
  logic [WORD_W:0]          mag;

  always_comb begin
    pre_nxt     = '0;
    pre_nxt.tag = in_tag;
    pre_nxt.dv  = (in_tag.mode == MODE_INV) ? DIVS_W'(in_tag.ls) : DIVS_W'(in_root);
    for (int i = 0; i < 4; i++) begin
      ae  = (WORD_W + 1)'($signed(in_tag.a[i]));
      mag = (ae < 0) ? (WORD_W + 1)'(-ae) : (WORD_W + 1)'(ae);
      if ((in_tag.mode == MODE_INV) && (i < 3)) begin
        pre_nxt.neg[i] = (ae > 0);
      end else begin
        pre_nxt.neg[i] = (ae < 0);
      end
      pre_nxt.rem[i] = (NUM_W'(mag) << FRAC_W) + NUM_W'(pre_nxt.dv >> 1);
      pre_nxt.ovf[i] = (CMP_W'(pre_nxt.rem[i]) >= (CMP_W'(pre_nxt.dv) << QUO_W));
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    dstage_t src;
    if (k == 0) begin : g_first
      assign src = pre_r;
    end else begin : g_next
      assign src = st_r[k-1];
    end
    always_comb begin
      st_nxt[k] = src;
      for (int i = 0; i < 4; i++) begin
        if (CMP_W'(src.rem[i]) >= (CMP_W'(src.dv) << (QUO_W - 1 - k))) begin
          st_nxt[k].rem[i] = src.rem[i] - NUM_W'(CMP_W'(src.dv) << (QUO_W - 1 - k));
          st_nxt[k].q[i][QUO_W-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
      for (int k = 0; k < QUO_W; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      pre_v_r <= in_v;
      v_r[0]  <= pre_v_r;
      for (int k = 1; k < QUO_W; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
      for (int k = 0; k < QUO_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_v   = v_r[QUO_W-1];
  assign out_tag = st_r[QUO_W-1].tag;
  assign out_q   = st_r[QUO_W-1].q;
  assign out_neg = st_r[QUO_W-1].neg;
  assign out_ovf = st_r[QUO_W-1].ovf;

endmodule

// ===== rtl/quaternion_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Fixed-point quaternion unit: add, subtract, Hamilton product, scale,
// conjugate, invert, normalize and vector rotation, with saturated results.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready) with a mode, quaternion A and operand
// B in signed Q3.12; each request yields exactly one result on out_ch with the
// quaternion and the zero_norm and saturated flags, in request order.
// Invert's tolerance is written through cfg_we/cfg_wdata and resets to zero;
// the user writes it only while the unit is idle, which is not enforced.
// Every request travels the same pipeline: four arithmetic stages, eighteen
// square-root stages and seventeen divider stages, then the output register.
// While in_ch.ready is high one request is accepted per cycle, at full rate.
// Reset (rst_n low, synchronous) empties the pipeline and the output stage.
// The output register is backed by a one-entry skid buffer. When out_ch stalls
// the skid entry fills, in_ch.ready drops while it holds a result and the whole
// pipeline holds; nothing is dropped or repeated, and in_ch.ready depends
// only on registered state.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  qau_in_if.sink                      in_ch,
  qau_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [qau_pkg::TOL_W-1:0]   cfg_wdata
);
  import qau_pkg::*;

  typedef struct packed {
    quat_t r;
    logic  zn;
    logic  sat;
  } result_t;

  logic                    en;
  logic [TOL_W-1:0]        tol_r;
  quat_t                   in_a;
  quat_t                   in_b;
  logic                    ar_v;
  tag_t                    ar_tag;
  logic [SQ_W-1:0]         ar_sq;
  logic                    sq_v;
  tag_t                    sq_tag;
  logic [ROOT_W-1:0]       sq_root;
  logic                    dv_v;
  tag_t                    dv_tag;
  logic [3:0][QUO_W-1:0]   dv_q;
  logic [3:0]              dv_neg;
  logic [3:0]              dv_ovf;
  logic                    push;
  result_t                 push_d;
  logic [3:0]              sat_bits;
  logic                    out_v_r;
  result_t                 out_d_r;
  logic                    skid_v_r;
  result_t                 skid_d_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign in_a        = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign in_b        = {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  qau_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_ch.valid),
    .in_mode (mode_t'(in_ch.mode)),
    .in_a    (in_a),
    .in_b    (in_b),
    .tol     (tol_r),
    .out_v   (ar_v),
    .out_tag (ar_tag),
    .out_sq  (ar_sq)
  );

  qau_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (ar_v),
    .in_tag   (ar_tag),
    .in_x     (ar_sq),
    .out_v    (sq_v),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  qau_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (sq_v),
    .in_tag  (sq_tag),
    .in_root (sq_root),
    .out_v   (dv_v),
    .out_tag (dv_tag),
    .out_q   (dv_q),
    .out_neg (dv_neg),
    .out_ovf (dv_ovf)
  );

  assign push = en && dv_v;

  always_comb begin
    sat_bits = '0;
    push_d   = '0;
    for (int i = 0; i < 4; i++) begin
      if ((dv_tag.mode == MODE_INV) || (dv_tag.mode == MODE_NORM)) begin
        if (dv_tag.zn) begin
          push_d.r[i] = dv_tag.a[i];
        end else if (dv_ovf[i]) begin
          sat_bits[i] = 1'b1;
          push_d.r[i] = dv_neg[i] ? WMIN : WMAX;
        end else if (dv_neg[i]) begin
          if (dv_q[i] > (QUO_W'(1) << (WORD_W - 1))) begin
            sat_bits[i] = 1'b1;
            push_d.r[i] = WMIN;
          end else begin
            push_d.r[i] = WORD_W'(QUO_W'(0) - dv_q[i]);
          end
        end else if (dv_q[i] > QUO_W'(WMAX)) begin
          sat_bits[i] = 1'b1;
          push_d.r[i] = WMAX;
        end else begin
          push_d.r[i] = WORD_W'(dv_q[i]);
        end
      end else begin
        if ($signed(dv_tag.res[i]) > RES_W'(WMAX)) begin
          sat_bits[i] = 1'b1;
          push_d.r[i] = WMAX;
        end else if ($signed(dv_tag.res[i]) < RES_W'(WMIN)) begin
          sat_bits[i] = 1'b1;
          push_d.r[i] = WMIN;
        end else begin
          push_d.r[i] = WORD_W'(dv_tag.res[i]);
        end
      end
    end
    push_d.zn  = dv_tag.zn;
    push_d.sat = |sat_bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_d_r <= skid_v_r ? skid_d_r : push_d;
    end else if (push) begin
      skid_d_r <= push_d;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.r_x       = out_d_r.r[0];
  assign out_ch.r_y       = out_d_r.r[1];
  assign out_ch.r_z       = out_d_r.r[2];
  assign out_ch.r_w       = out_d_r.r[3];
  assign out_ch.zero_norm = out_d_r.zn;
  assign out_ch.saturated = out_d_r.sat;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a pending result");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid entry filled while the output was free");

  a_zero_norm_unsaturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.zn) |-> !out_d_r.sat)
    else $error("zero-norm result flagged as saturated");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the quaternion arithmetic unit. Requests are driven through
// the request channel with random gaps, and the result channel is stalled at
// random. A scoreboard predicts each result from the accepted request and the
// current invert tolerance, then compares every field in order. The tolerance
// is changed between phases while the unit is idle, including both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import qau_pkg::*;

  typedef struct {
    mode_t                    mode;
    logic signed [WORD_W-1:0] a [4];
    logic signed [WORD_W-1:0] b [4];
  } quat_request_t;

  typedef struct {
    logic [WORD_W-1:0] r [4];
    logic              zn;
    logic              sat;
  } quat_result_t;

  class quat_scoreboard;
    longint       tolerance;
    quat_result_t expected_q[$];
    int           errors;
    int           checked;
    int           mode_count [8];
    int           zn_count;
    int           sat_count;

    function new();
      tolerance = 0;
      errors = 0;
      checked = 0;
      zn_count = 0;
      sat_count = 0;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    function longint round_mul(longint x, longint y);
      return (x * y + HALF) >>> FRAC_W;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint round_div(longint n, longint d);
      longint m;
      longint q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
    endfunction

    function longint root_nearest(longint x);
      longint r;
      longint bitv;
      r = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > x) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (x >= r + bitv) begin
          x = x - (r + bitv);
          r = (r >>> 1) + bitv;
        end else begin
          r = r >>> 1;
        end
        bitv = bitv >>> 2;
      end
      if (x > r) r++;
      return r;
    endfunction

    function quat_result_t compute_quat(quat_request_t q);
      quat_result_t res;
      longint a [4];
      longint b [4];
      longint r [4];
      longint c [3];
      longint s, ls, len, d, vv, k;
      bit skip;
      res.zn = 0;
      res.sat = 0;
      skip = 0;
      for (int i = 0; i < 4; i++) begin
        a[i] = q.a[i];
        b[i] = q.b[i];
        r[i] = 0;
      end
      s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
      case (q.mode)
        MODE_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
        MODE_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
        MODE_MUL: begin
          r[0] = round_mul(a[3], b[0]) + round_mul(a[0], b[3])
               + round_mul(a[1], b[2]) - round_mul(a[2], b[1]);
          r[1] = round_mul(a[3], b[1]) - round_mul(a[0], b[2])
               + round_mul(a[1], b[3]) + round_mul(a[2], b[0]);
          r[2] = round_mul(a[3], b[2]) + round_mul(a[0], b[1])
               - round_mul(a[1], b[0]) + round_mul(a[2], b[3]);
          r[3] = round_mul(a[3], b[3]) - round_mul(a[0], b[0])
               - round_mul(a[1], b[1]) - round_mul(a[2], b[2]);
        end
        MODE_SCALE: for (int i = 0; i < 4; i++) r[i] = round_mul(a[i], b[3]);
        MODE_CONJ: begin
          r[0] = -a[0];
          r[1] = -a[1];
          r[2] = -a[2];
          r[3] = a[3];
        end
        MODE_INV: begin
          ls = (s >>> FRAC_W) + ((s >>> (FRAC_W - 1)) & 1);
          if (ls <= tolerance) begin
            skip = 1;
          end else begin
            for (int i = 0; i < 3; i++) r[i] = round_div(-a[i] * (1 << FRAC_W), ls);
            r[3] = round_div(a[3] * (1 << FRAC_W), ls);
          end
        end
        MODE_NORM: begin
          if (s == 0) begin
            skip = 1;
          end else begin
            len = root_nearest(s);
            for (int i = 0; i < 4; i++) r[i] = round_div(a[i] * (1 << FRAC_W), len);
          end
        end
        default: begin
          d = clip32(round_mul(a[0], b[0]) + round_mul(a[1], b[1]) + round_mul(a[2], b[2]));
          vv = clip32(round_mul(a[0], a[0]) + round_mul(a[1], a[1]) + round_mul(a[2], a[2]));
          k = clip32(round_mul(a[3], a[3]) - vv);
          c[0] = clip32(round_mul(a[1], b[2]) - round_mul(a[2], b[1]));
          c[1] = clip32(round_mul(a[2], b[0]) - round_mul(a[0], b[2]));
          c[2] = clip32(round_mul(a[0], b[1]) - round_mul(a[1], b[0]));
          for (int i = 0; i < 3; i++)
            r[i] = 2 * round_mul(d, a[i]) + round_mul(k, b[i]) + 2 * round_mul(a[3], c[i]);
          r[3] = 0;
        end
      endcase
      if (skip) begin
        res.zn = 1;
        for (int i = 0; i < 4; i++) r[i] = a[i];
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (r[i] > 32767) begin
            r[i] = 32767;
            res.sat = 1;
          end else if (r[i] < -32768) begin
            r[i] = -32768;
            res.sat = 1;
          end
        end
      end
      for (int i = 0; i < 4; i++) res.r[i] = r[i][WORD_W-1:0];
      return res;
    endfunction

    function void note_request(quat_request_t q);
      quat_result_t res;
      res = compute_quat(q);
      mode_count[q.mode]++;
      if (res.zn) zn_count++;
      if (res.sat) sat_count++;
      expected_q.push_back(res);
    endfunction

    task report(string what);
      $display("mismatch at result %0d: %s", checked, what);
      errors++;
    endtask

    task check_result(quat_result_t got);
      quat_result_t exp;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp = expected_q.pop_front();
      for (int i = 0; i < 4; i++)
        if (got.r[i] !== exp.r[i])
          report($sformatf("component %0d got %h expected %h", i, got.r[i], exp.r[i]));
      if (got.zn !== exp.zn)
        report($sformatf("zero_norm got %b expected %b", got.zn, exp.zn));
      if (got.sat !== exp.sat)
        report($sformatf("saturated got %b expected %b", got.sat, exp.sat));
      checked++;
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;
  bit               steady;
  longint           cycles = 0;

  qau_in_if  in_ch();
  qau_out_if out_ch();

  quat_scoreboard quat_sb = new();

  quaternion_arithmetic_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    quat_request_t q;
    quat_result_t  res;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      q.mode = mode_t'(in_ch.mode);
      q.a[0] = in_ch.a_x;
      q.a[1] = in_ch.a_y;
      q.a[2] = in_ch.a_z;
      q.a[3] = in_ch.a_w;
      q.b[0] = in_ch.b_x;
      q.b[1] = in_ch.b_y;
      q.b[2] = in_ch.b_z;
      q.b[3] = in_ch.b_w;
      quat_sb.note_request(q);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res.r[0] = out_ch.r_x;
      res.r[1] = out_ch.r_y;
      res.r[2] = out_ch.r_z;
      res.r[3] = out_ch.r_w;
      res.zn = out_ch.zero_norm;
      res.sat = out_ch.saturated;
      quat_sb.check_result(res);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= steady || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_component();
    case ($urandom_range(9))
      0, 1, 2: return WORD_W'($urandom);
      3:       return $urandom_range(1) ? WMAX : WMIN;
      4:       return WORD_W'(int'($urandom_range(80)) - 40);
      default: return WORD_W'(int'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic quat_request_t make_random();
    quat_request_t q;
    int near_zero;
    q.mode = mode_t'($urandom_range(7));
    near_zero = (q.mode == MODE_INV && $urandom_range(2) == 0) ? 1 : 0;
    for (int i = 0; i < 4; i++) begin
      q.a[i] = near_zero ? WORD_W'(int'($urandom_range(128)) - 64) : pick_component();
      q.b[i] = pick_component();
    end
    if (q.mode inside {MODE_INV, MODE_NORM} && $urandom_range(15) == 0)
      foreach (q.a[i]) q.a[i] = '0;
    return q;
  endfunction

  function automatic quat_request_t make_request(mode_t m, int ax, int ay, int az, int aw,
                                                 int bx, int by, int bz, int bw);
    quat_request_t q;
    q.mode = m;
    q.a[0] = WORD_W'(ax);
    q.a[1] = WORD_W'(ay);
    q.a[2] = WORD_W'(az);
    q.a[3] = WORD_W'(aw);
    q.b[0] = WORD_W'(bx);
    q.b[1] = WORD_W'(by);
    q.b[2] = WORD_W'(bz);
    q.b[3] = WORD_W'(bw);
    return q;
  endfunction

  task send_request(quat_request_t q);
    if (!steady && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= q.mode;
    in_ch.a_x   <= q.a[0];
    in_ch.a_y   <= q.a[1];
    in_ch.a_z   <= q.a[2];
    in_ch.a_w   <= q.a[3];
    in_ch.b_x   <= q.b[0];
    in_ch.b_y   <= q.b[1];
    in_ch.b_z   <= q.b[2];
    in_ch.b_w   <= q.b[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (quat_sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_tolerance(logic [TOL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    quat_sb.tolerance = v;
    @(posedge clk);
  endtask

  task send_random(int n);
    repeat (n) send_request(make_random());
  endtask

  initial begin
    quat_request_t directed [$];
    steady = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w} = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_request(MODE_ADD, 32767, -32768, 4096, 0, 1, -1, 4096, 0));
    directed.push_back(make_request(MODE_SUB, -32768, 32767, 0, 1, 1, -1, 0, -1));
    directed.push_back(make_request(MODE_MUL, 4096, 0, 0, 0, 0, 4096, 0, 0));
    directed.push_back(make_request(MODE_MUL, 32767, 32767, -32768, 32767,
                                    32767, -32768, 32767, 32767));
    directed.push_back(make_request(MODE_SCALE, 2048, -2048, 1, -1, 0, 0, 0, 2048));
    directed.push_back(make_request(MODE_SCALE, 32767, -32768, 100, 0, 0, 0, 0, -32768));
    directed.push_back(make_request(MODE_CONJ, -32768, 32767, 0, -32768, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_INV, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_INV, 0, 0, 0, 4096, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_INV, 45, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_INV, 46, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_INV, 1, 1, 1, 1, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_INV, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_NORM, 0, 0, 0, 0, 5, 5, 5, 5));
    directed.push_back(make_request(MODE_NORM, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_NORM, 3000, -4000, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_NORM, -32768, 32767, -32768, 32767, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_ROT, 0, 0, 2896, 2896, 4096, 0, 0, 0));
    directed.push_back(make_request(MODE_ROT, -32768, -32768, -32768, 32767,
                                    32767, -32768, 32767, 0));
    directed.push_back(make_request(MODE_ROT, 32767, 32767, 32767, -32768,
                                    -32768, -32768, -32768, -32768));
    foreach (directed[i]) send_request(directed[i]);
    send_random(250);
    drain_and_settle();

    write_tolerance(12'hFFF);
    steady = 1;
    send_random(150);
    steady = 0;
    send_random(150);
    drain_and_settle();

    write_tolerance(TOL_W'($urandom_range(1, 4094)));
    send_random(200);
    drain_and_settle();

    write_tolerance(12'd1);
    directed.delete();
    directed.push_back(make_request(MODE_INV, 0, 0, 0, 45, 0, 0, 0, 0));
    directed.push_back(make_request(MODE_INV, 0, 0, 0, 64, 0, 0, 0, 0));
    foreach (directed[i]) send_request(directed[i]);
    send_random(230);
    drain_and_settle();

    $display("checked %0d results: add %0d sub %0d mul %0d scale %0d conj %0d",
             quat_sb.checked, quat_sb.mode_count[0], quat_sb.mode_count[1],
             quat_sb.mode_count[2], quat_sb.mode_count[3], quat_sb.mode_count[4]);
    $display("inv %0d norm %0d rot %0d, zero-norm skips %0d, saturated %0d",
             quat_sb.mode_count[5], quat_sb.mode_count[6], quat_sb.mode_count[7],
             quat_sb.zn_count, quat_sb.sat_count);
    if (quat_sb.errors == 0 && quat_sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
